FILE: sv/brppe_pkg.sv
// ---------------------------------------------------------------------------
// brppe_pkg
// Shared types and constants for the bit run pulse pair encoder.
// ---------------------------------------------------------------------------
package brppe_pkg;

    // Tick rate and duration field width.
    localparam int unsigned TICKS_PER_US  = 1;
    localparam int unsigned DURATION_BITS = 15;
    localparam int unsigned TE_BITS       = 16;

    // Width of one run increment (te_us times the tick rate).
    localparam int unsigned INC_BITS = TE_BITS + $clog2(TICKS_PER_US + 1);
    // Width of the sum before saturation.
    localparam int unsigned SUM_BITS =
        ((INC_BITS > DURATION_BITS) ? INC_BITS : DURATION_BITS) + 1;

    localparam logic [DURATION_BITS-1:0] DUR_MAX = '1;
    localparam logic [TE_BITS-1:0]       TE_RESET = TE_BITS'(100);

    // Result buffer depth.
    localparam int unsigned BUF_DEPTH = 4;
    localparam int unsigned BUF_AW    = $clog2(BUF_DEPTH);

    // One pulse item.
    typedef struct packed {
        logic                     block_end;
        logic [DURATION_BITS-1:0] duration_second;
        logic                     level_second;
        logic [DURATION_BITS-1:0] duration_first;
        logic                     level_first;
    } t_pulse_item;

endpackage

FILE: sv/bit_run_pulse_pair_encoder.sv
// Result items are written into a four-entry result buffer and offered from it in order.
// Throughput: one bit per cycle unless input is held off; a bit that closes a pair and
// ends its block yields two items, which leave one per cycle while i_m_axis_tready is high.
// Input is held off only while fewer than two buffer entries are free.
// Reset (i_rst_n low, synchronous) clears the run state and the buffer and sets te_us to 100.
// ---------------------------------------------------------------------------
// bit_run_pulse_pair_encoder
// Merges runs of equal bits into timed levels and pairs them into pulse items.
// ---------------------------------------------------------------------------
module bit_run_pulse_pair_encoder
    import brppe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel: te_us.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    // Input bits.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [0] bit_value, [7:1] zero
    input  logic        i_s_axis_tlast,   // block_last
    // Pulse items.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [0] level_first, [15:1] duration_first,
                                          // [16] level_second, [31:17] duration_second
    output logic        o_m_axis_tlast    // block_end
);

    // Run and pairing state.
    logic                     r_run_open, n_run_open;
    logic                     r_run_level, n_run_level;
    logic [DURATION_BITS-1:0] r_run_ticks, n_run_ticks;
    logic                     r_half_held, n_half_held;
    logic                     r_held_level, n_held_level;
    logic [DURATION_BITS-1:0] r_held_ticks, n_held_ticks;
    logic [TE_BITS-1:0]       r_te_us;

    // Result buffer.
    t_pulse_item              r_buf [BUF_DEPTH];
    logic [BUF_AW-1:0]        r_wr_ptr, n_wr_ptr;
    logic [BUF_AW-1:0]        r_rd_ptr, n_rd_ptr;
    logic [BUF_AW:0]          r_count, n_count;

    logic                     in_xfer;
    logic                     out_xfer;
    logic                     bit_in;
    logic                     last_in;
    logic                     new_run;
    logic [INC_BITS-1:0]      inc;
    logic [SUM_BITS-1:0]      sum;
    logic [DURATION_BITS-1:0] base_ticks;
    logic [DURATION_BITS-1:0] run_sat;
    logic                     held_mid;
    logic [1:0]               n_push;
    t_pulse_item              item_a;
    t_pulse_item              item_b;

    assign o_cfg_ready     = 1'b1;
    assign bit_in          = i_s_axis_tdata[0];
    assign last_in         = i_s_axis_tlast;
    assign o_s_axis_tready = (r_count <= (BUF_AW+1)'(BUF_DEPTH - 2));
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = (r_count != '0);
    assign out_xfer        = o_m_axis_tvalid && i_m_axis_tready;
    assign o_m_axis_tdata  = {r_buf[r_rd_ptr].duration_second,
                              r_buf[r_rd_ptr].level_second,
                              r_buf[r_rd_ptr].duration_first,
                              r_buf[r_rd_ptr].level_first};
    assign o_m_axis_tlast  = r_buf[r_rd_ptr].block_end;

    // Saturating run accumulation.
    assign inc = INC_BITS'(r_te_us * TICKS_PER_US);

    always_comb begin
        new_run    = !r_run_open || (bit_in != r_run_level);
        base_ticks = new_run ? '0 : r_run_ticks;
        sum        = SUM_BITS'(base_ticks) + SUM_BITS'(inc);
        run_sat    = (sum > SUM_BITS'(DUR_MAX)) ? DUR_MAX : sum[DURATION_BITS-1:0];
    end

    // Run closing and pairing for one bit.
    always_comb begin
        n_run_open   = r_run_open;
        n_run_level  = r_run_level;
        n_run_ticks  = r_run_ticks;
        n_half_held  = r_half_held;
        n_held_level = r_held_level;
        n_held_ticks = r_held_ticks;
        n_push       = 2'd0;
        item_a       = '0;
        item_b       = '0;
        held_mid     = r_half_held;

        if (in_xfer) begin
            // A level change closes the open run.
            if (r_run_open && (bit_in != r_run_level)) begin
                if (r_half_held) begin
                    item_a = '{block_end: 1'b0, duration_second: r_run_ticks,
                               level_second: r_run_level, duration_first: r_held_ticks,
                               level_first: r_held_level};
                    n_push   = 2'd1;
                    held_mid = 1'b0;
                end else begin
                    n_held_level = r_run_level;
                    n_held_ticks = r_run_ticks;
                    held_mid     = 1'b1;
                end
            end
            n_half_held = held_mid;
            n_run_open  = 1'b1;
            n_run_level = bit_in;
            n_run_ticks = run_sat;

            // Block end closes the current run and flushes any unpaired half.
            if (last_in) begin
                n_run_open  = 1'b0;
                n_half_held = 1'b0;
                if (held_mid) begin
                    item_b = '{block_end: 1'b1, duration_second: run_sat,
                               level_second: bit_in, duration_first: n_held_ticks,
                               level_first: n_held_level};
                end else begin
                    item_b = '{block_end: 1'b1, duration_second: '0,
                               level_second: 1'b0, duration_first: run_sat,
                               level_first: bit_in};
                end
                if (n_push == 2'd1) begin
                    n_push = 2'd2;
                end else begin
                    item_a = item_b;
                    n_push = 2'd1;
                end
            end
        end
    end

    // Buffer pointer and fill count.
    always_comb begin
        n_wr_ptr = r_wr_ptr + BUF_AW'(n_push);
        n_rd_ptr = r_rd_ptr + BUF_AW'(out_xfer);
        n_count  = r_count + (BUF_AW+1)'(n_push) - (BUF_AW+1)'(out_xfer);
    end

    // State, configuration and buffer control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_open   <= 1'b0;
            r_run_level  <= 1'b0;
            r_run_ticks  <= '0;
            r_half_held  <= 1'b0;
            r_held_level <= 1'b0;
            r_held_ticks <= '0;
            r_te_us      <= TE_RESET;
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
            r_count      <= '0;
        end else begin
            r_run_open   <= n_run_open;
            r_run_level  <= n_run_level;
            r_run_ticks  <= n_run_ticks;
            r_half_held  <= n_half_held;
            r_held_level <= n_held_level;
            r_held_ticks <= n_held_ticks;
            r_wr_ptr     <= n_wr_ptr;
            r_rd_ptr     <= n_rd_ptr;
            r_count      <= n_count;
            if (i_cfg_valid && o_cfg_ready) begin
                r_te_us <= i_cfg_data;
            end
        end
    end

    // Buffer payload, no reset needed.
    always_ff @(posedge i_clk) begin
        if (n_push != 2'd0) begin
            r_buf[r_wr_ptr] <= item_a;
        end
        if (n_push == 2'd2) begin
            r_buf[r_wr_ptr + BUF_AW'(1)] <= item_b;
        end
    end

endmodule

FILE: sv/brppe_checker.sv
// ---------------------------------------------------------------------------
// brppe_checker
// Port-level checks on the bit run pulse pair encoder, bound to the top level.
// ---------------------------------------------------------------------------
module brppe_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_cfg_ready,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast
);

    // A stalled pulse item stays offered with the same content.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
        (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast)))
        else $error("pulse item changed while stalled");

    // After reset the result buffer is empty.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result offered straight after reset");

    // After reset there is room for a bit.
    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_s_axis_tready)
        else $error("input held off straight after reset");

    // With the buffer empty there is always room for a bit.
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input held off with no result pending");

    // The configuration channel never stalls.
    a_cfg_ready: assert property (@(posedge i_clk) o_cfg_ready)
        else $error("configuration channel stalled");

endmodule

bind bit_run_pulse_pair_encoder brppe_checker u_brppe_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_cfg_ready     (o_cfg_ready),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
